/* hdl/lfch_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfch_pkg
// shared types and constants of the loss-free counting histogram
// ----------------------------------------------------------------------------
package lfch_pkg;

  localparam int unsigned ENERGY_BITS_DEF = 12;
  localparam int unsigned CNT_W           = 48;
  localparam int unsigned RUN_W           = 32;
  localparam int unsigned ACC_W           = 56;
  localparam int unsigned TOT_W           = 64;
  localparam int unsigned IN_TDATA_W      = 272;
  localparam int unsigned OUT_TDATA_W     = 96;
  localparam int unsigned CFG_W           = 12;
  localparam logic [31:0] US_PER_S        = 32'd1000000;

  // divider geometry: (peaks * real * 2^16) / fast live
  localparam int unsigned DVD_W = 2 * CNT_W + 16;
  localparam int unsigned DVS_W = CNT_W;

  typedef enum logic [1:0] {
    CMD_HIT   = 2'd0,
    CMD_STATS = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_MONITOR  = 1'b0,
    REG_INTERVAL = 1'b1
  } reg_e;

  // one bin entry in the bin memory
  typedef struct packed {
    logic [CNT_W-1:0] shown;
    logic [ACC_W-1:0] accum;
    logic [RUN_W-1:0] run;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

/* hdl/lfch_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfch_ram
// single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module lfch_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

/* hdl/lfch_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfch_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lfch_div #(
  parameter int unsigned DVD_W = 112,
  parameter int unsigned DVS_W = 48
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output      logic             done_o,
  output      logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W:0]   trial;
  logic             qbit;

  assign trial      = {rem_q, dvd_q[DVD_W-1]};
  assign qbit       = (trial >= {1'b0, dvs_q});
  assign quotient_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_o <= 1'b0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
        cnt_q  <= CW'(DVD_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= qbit ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
        dvd_q <= {dvd_q[DVD_W-2:0], qbit};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/loss_free_counting_histogram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// loss_free_counting_histogram
// energy histogram with loss-free counting compensation
// ----------------------------------------------------------------------------
// hit: acceptance, then a read-modify-write of the bin memory
// read: the bin is read, then the result is registered once the output register
// is free or taken; ignored or first stats request: completed at acceptance
// refresh: a read and a write of every bin; update: a multiply, two bit-serial
// divisions and the bin sweep; no hits: the second division and sweep are skipped
// one request in work at a time; after reset a clearing pass zeroes every bin
module loss_free_counting_histogram
  import lfch_pkg::*;
#(
  parameter int unsigned ENERGY_BITS = ENERGY_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration writes
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i,
  // request stream
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // energy[11:0], channel[15:12], lab_time_us[63:16], real_ticks[111:64],
  // live_ticks[159:112], fast_dead_ticks[207:160], fast_peak_total[255:208],
  // bin_index[267:256], zero fill [271:268]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  wire logic [1:0]             s_axis_tuser,
  // result stream
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // bin_value[47:0], shown total[95:48]
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned AW    = ENERGY_BITS;
  localparam int unsigned NBINS = 1 << ENERGY_BITS;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HIT_RD, S_HIT_WR, S_RD_RD, S_RD_OUT,
    S_CHK, S_UPD0, S_MUL, S_DV1_GO, S_DV1_WAIT, S_ACC, S_DV2_GO, S_DV2_WAIT,
    S_SW_RD, S_SW_M1, S_SW_M2, S_SW_M3, S_SW_WR, S_RF_RD, S_RF_WR
  } state_e;

  state_e state_q;

  // input field unpacking
  logic [1:0]       in_cmd;
  logic [11:0]      in_energy;
  logic [3:0]       in_src;
  logic [CNT_W-1:0] in_lab, in_real, in_live, in_fd, in_pk;
  logic [11:0]      in_bin;
  logic             in_acc;

  assign in_cmd    = s_axis_tuser;
  assign in_energy = s_axis_tdata[11:0];
  assign in_src    = s_axis_tdata[15:12];
  assign in_lab    = s_axis_tdata[63:16];
  assign in_real   = s_axis_tdata[111:64];
  assign in_live   = s_axis_tdata[159:112];
  assign in_fd     = s_axis_tdata[207:160];
  assign in_pk     = s_axis_tdata[255:208];
  assign in_bin    = s_axis_tdata[267:256];
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);

  // configuration
  logic [3:0]  mon_q;
  logic [11:0] intv_q;
  logic [31:0] thresh_q;   // (interval + 1) seconds in microseconds

  // sample and reference
  logic [CNT_W-1:0] lab_q, real_q, live_q, fd_q, pk_q;
  logic [CNT_W-1:0] ref_lab_q, ref_real_q, ref_live_q, ref_fd_q, ref_pk_q;
  logic             have_ref_q;
  logic [CNT_W-1:0] dreal_q, dlive_q, dfd_q, dpk_q, fl_q;

  // compensation arithmetic
  logic [2:0]          mul_cnt_q;
  logic [CNT_W-1:0]    pp_q;
  logic [1:0]          pp_sh_q;
  logic [2*CNT_W-1:0]  prod_q;
  logic [TOT_W-1:0]    comp_q, ctot_q, stot_q, factor_q;
  logic [RUN_W-1:0]    hits_q;

  // bin sweep
  logic [AW-1:0]       addr_q;
  entry_t              word_q;
  logic [59:0]         pl_q, ph_q;
  logic [ACC_W-1:0]    add_q;

  // output register
  logic [CNT_W-1:0]    out_bin_q, out_tot_q;
  logic                out_vld_q;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_tot_q, out_bin_q};

  // bin memory
  logic             ram_we;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  assign ram_rdata = entry_t'(ram_rdata_raw);

  lfch_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NBINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (addr_q),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata_raw)
  );

  // shared divider
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_q;

  assign div_start = (state_q == S_DV1_GO) || (state_q == S_DV2_GO);
  assign div_dvd   = (state_q == S_DV1_GO) ? {prod_q, 16'd0}
                                           : DVD_W'(comp_q);
  assign div_dvs   = (state_q == S_DV1_GO) ? fl_q : DVS_W'(hits_q);

  lfch_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // datapath helpers
  logic [CNT_W-1:0]   lab_diff;
  logic               do_update;
  logic [23:0]        mul_a, mul_b;
  logic [2*CNT_W-1:0] pp_shifted;
  logic [TOT_W-1:0]   comp_sat;
  logic [TOT_W:0]     ctot_sum;
  logic [TOT_W-1:0]   ctot_new;
  logic [TOT_W:0]     stot_sum;
  logic [87:0]        sw_prod;
  logic [ACC_W-1:0]   sw_add;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_new;
  entry_t             hit_word, sw_word, rf_word;
  logic               last_bin;

  assign lab_diff  = lab_q - ref_lab_q;
  assign do_update = (lab_q >= ref_lab_q) && (lab_diff >= CNT_W'(thresh_q));
  assign mul_a     = mul_cnt_q[1] ? dpk_q[47:24] : dpk_q[23:0];
  assign mul_b     = mul_cnt_q[0] ? dreal_q[47:24] : dreal_q[23:0];
  assign last_bin  = (addr_q == {AW{1'b1}});

  always_comb begin
    case (pp_sh_q)
      2'd0:    pp_shifted = {48'd0, pp_q};
      2'd1:    pp_shifted = {24'd0, pp_q, 24'd0};
      default: pp_shifted = {pp_q, 48'd0};
    endcase
  end

  // quotient above 64 bits saturates
  assign comp_sat = (|div_q[DVD_W-1:TOT_W]) ? {TOT_W{1'b1}} : div_q[TOT_W-1:0];
  assign ctot_sum = {1'b0, ctot_q} + {1'b0, comp_q};
  assign ctot_new = ctot_sum[TOT_W] ? {TOT_W{1'b1}} : ctot_sum[TOT_W-1:0];
  assign stot_sum = {1'b0, stot_q} + {17'd0, hits_q, 16'd0};

  // factor times run count, saturating at the accumulator range
  assign sw_prod = {28'd0, pl_q} + {ph_q, 28'd0};
  always_comb begin
    if (|factor_q[TOT_W-1:ACC_W]) begin
      sw_add = (word_q.run != '0) ? {ACC_W{1'b1}} : '0;
    end else if (|sw_prod[87:ACC_W]) begin
      sw_add = {ACC_W{1'b1}};
    end else begin
      sw_add = sw_prod[ACC_W-1:0];
    end
  end

  assign acc_sum = {1'b0, word_q.accum} + {1'b0, add_q};
  assign acc_new = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

  always_comb begin
    hit_word     = ram_rdata;
    hit_word.run = (ram_rdata.run == {RUN_W{1'b1}}) ? ram_rdata.run
                                                    : ram_rdata.run + 1'b1;
    sw_word       = word_q;
    sw_word.run   = '0;
    sw_word.accum = acc_new;
    if (acc_new != '0) begin
      sw_word.shown = CNT_W'(acc_new[ACC_W-1:16]);
    end
    rf_word = ram_rdata;
    if ((ram_rdata.run != '0) || (ram_rdata.accum != '0)) begin
      rf_word.shown = CNT_W'(ram_rdata.run) + CNT_W'(ram_rdata.accum[ACC_W-1:16]);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    unique case (state_q)
      S_CLEAR:  ram_we = 1'b1;
      S_HIT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = hit_word;
      end
      S_SW_WR: begin
        ram_we    = 1'b1;
        ram_wdata = sw_word;
      end
      S_RF_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rf_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      mon_q      <= '0;
      intv_q     <= 12'd1;
      thresh_q   <= '0;
      lab_q      <= '0;
      real_q     <= '0;
      live_q     <= '0;
      fd_q       <= '0;
      pk_q       <= '0;
      ref_lab_q  <= '0;
      ref_real_q <= '0;
      ref_live_q <= '0;
      ref_fd_q   <= '0;
      ref_pk_q   <= '0;
      have_ref_q <= 1'b0;
      dreal_q    <= '0;
      dlive_q    <= '0;
      dfd_q      <= '0;
      dpk_q      <= '0;
      fl_q       <= '0;
      mul_cnt_q  <= '0;
      pp_q       <= '0;
      pp_sh_q    <= '0;
      prod_q     <= '0;
      comp_q     <= '0;
      ctot_q     <= '0;
      stot_q     <= '0;
      factor_q   <= '0;
      hits_q     <= '0;
      addr_q     <= '0;
      word_q     <= '0;
      pl_q       <= '0;
      ph_q       <= '0;
      add_q      <= '0;
      out_bin_q  <= '0;
      out_tot_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      // configuration, to be written only while idle; the block does not enforce this
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_MONITOR:  mon_q  <= cfg_data_i[3:0];
          REG_INTERVAL: intv_q <= cfg_data_i;
          default: ;
        endcase
      end
      thresh_q <= 32'({1'b0, intv_q} + 13'd1) * US_PER_S;

      // a read in its output cycle reloads the register itself
      if (out_vld_q && m_axis_tready && (state_q != S_RD_OUT)) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          addr_q <= addr_q + 1'b1;
          if (last_bin) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            lab_q  <= in_lab;
            real_q <= in_real;
            live_q <= in_live;
            fd_q   <= in_fd;
            pk_q   <= in_pk;
            case (cmd_e'(in_cmd))
              CMD_HIT: begin
                addr_q  <= AW'(in_energy);
                state_q <= S_HIT_RD;
                if (hits_q != {RUN_W{1'b1}}) begin
                  hits_q <= hits_q + 1'b1;
                end
              end
              CMD_READ: begin
                addr_q  <= AW'(in_bin);
                state_q <= S_RD_RD;
              end
              CMD_STATS: begin
                if (in_src == mon_q) begin
                  if (!have_ref_q) begin
                    // first sample only sets the reference
                    ref_lab_q  <= in_lab;
                    ref_real_q <= in_real;
                    ref_live_q <= in_live;
                    ref_fd_q   <= in_fd;
                    ref_pk_q   <= in_pk;
                    have_ref_q <= 1'b1;
                  end else begin
                    state_q <= S_CHK;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        S_HIT_RD: state_q <= S_HIT_WR;
        S_HIT_WR: state_q <= S_IDLE;

        S_RD_RD: state_q <= S_RD_OUT;
        S_RD_OUT: begin
          if (!out_vld_q || m_axis_tready) begin
            out_bin_q <= ram_rdata.shown;
            out_tot_q <= stot_q[TOT_W-1:16];
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end

        S_CHK: begin
          addr_q <= '0;
          if (do_update) begin
            dreal_q    <= real_q - ref_real_q;
            dlive_q    <= live_q - ref_live_q;
            dfd_q      <= fd_q - ref_fd_q;
            dpk_q      <= pk_q - ref_pk_q;
            ref_lab_q  <= lab_q;
            ref_real_q <= real_q;
            ref_live_q <= live_q;
            ref_fd_q   <= fd_q;
            ref_pk_q   <= pk_q;
            state_q    <= S_UPD0;
          end else begin
            state_q <= S_RF_RD;
          end
        end

        S_UPD0: begin
          // zero real time or no fast live time: reference only
          if ((dreal_q == '0) || (dlive_q <= dfd_q)) begin
            state_q <= S_IDLE;
          end else begin
            fl_q      <= dlive_q - dfd_q;
            prod_q    <= '0;
            mul_cnt_q <= '0;
            state_q   <= S_MUL;
          end
        end

        // 48x48 product from four 24x24 partial products
        S_MUL: begin
          if (mul_cnt_q != 3'd4) begin
            pp_q    <= mul_a * mul_b;
            pp_sh_q <= {1'b0, mul_cnt_q[1]} + {1'b0, mul_cnt_q[0]};
          end
          if (mul_cnt_q != 3'd0) begin
            prod_q <= prod_q + pp_shifted;
          end
          mul_cnt_q <= mul_cnt_q + 1'b1;
          if (mul_cnt_q == 3'd4) begin
            state_q <= S_DV1_GO;
          end
        end

        S_DV1_GO: state_q <= S_DV1_WAIT;
        S_DV1_WAIT: begin
          if (div_done) begin
            comp_q  <= comp_sat;
            state_q <= S_ACC;
          end
        end

        S_ACC: begin
          ctot_q <= ctot_new;
          stot_q <= ctot_new;
          // no hits: totals only, the sweep is skipped
          state_q <= (hits_q == '0) ? S_IDLE : S_DV2_GO;
        end

        S_DV2_GO: state_q <= S_DV2_WAIT;
        S_DV2_WAIT: begin
          if (div_done) begin
            factor_q <= div_q[TOT_W-1:0];
            state_q  <= S_SW_RD;
          end
        end

        S_SW_RD: state_q <= S_SW_M1;
        S_SW_M1: begin
          word_q  <= ram_rdata;
          pl_q    <= factor_q[27:0] * ram_rdata.run;
          state_q <= S_SW_M2;
        end
        S_SW_M2: begin
          ph_q    <= factor_q[55:28] * word_q.run;
          state_q <= S_SW_M3;
        end
        S_SW_M3: begin
          add_q   <= sw_add;
          state_q <= S_SW_WR;
        end
        S_SW_WR: begin
          addr_q <= addr_q + 1'b1;
          if (last_bin) begin
            hits_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SW_RD;
          end
        end

        S_RF_RD: state_q <= S_RF_WR;
        S_RF_WR: begin
          addr_q <= addr_q + 1'b1;
          if (last_bin) begin
            stot_q  <= stot_sum[TOT_W] ? {TOT_W{1'b1}} : stot_sum[TOT_W-1:0];
            state_q <= S_IDLE;
          end else begin
            state_q <= S_RF_RD;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
